### rtl/bfpa_pkg.sv
`timescale 1ns / 1ps
package bfpa_pkg;

  typedef logic [7:0] char_t;

  localparam int NUM_CHARS = 6;
  localparam int CNT_W = $clog2(NUM_CHARS + 1);

  localparam int VALUE_W = 32;
  localparam int RAW_W = 18;
  localparam int SCALED_W = 17;
  localparam logic [VALUE_W-2:0] LIMIT_EXCL = 31'd256000;

  localparam char_t ASCII_ZERO = 8'd48;
  localparam char_t ASCII_STAR = 8'h2A;
  localparam char_t ASCII_POINT = 8'h2E;
  localparam char_t ASCII_SPACE = 8'h20;

  // reciprocal constants, exact floor for any 17-bit dividend
  localparam int RECIP_W = 18;
  localparam int PROD_W = SCALED_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_10 = 18'd209716;
  localparam int SHIFT_10 = 21;
  localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;
  localparam int SHIFT_100 = 24;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 18'd134218;
  localparam int SHIFT_1000 = 27;
  localparam logic [RECIP_W-1:0] RECIP_10000 = 18'd214749;
  localparam int SHIFT_10000 = 31;

endpackage

### rtl/bfpa_serializer.sv
`timescale 1ns / 1ps
module bfpa_serializer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  bfpa_pkg::char_t      chars [bfpa_pkg::NUM_CHARS],
  output logic                 strobe,
  output bfpa_pkg::char_t      character,
  output logic                 last
);
  import bfpa_pkg::*;

  char_t            buffer [NUM_CHARS];
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (load) begin
      count <= CNT_W'(NUM_CHARS);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buffer <= chars;
    end else begin
      for (int i = 0; i < NUM_CHARS - 1; i++) begin
        buffer[i] <= buffer[i+1];
      end
      buffer[NUM_CHARS-1] <= buffer[NUM_CHARS-1];
    end
  end

  assign strobe = (count != '0);
  assign character = buffer[0];
  assign last = (count == CNT_W'(1));

endmodule

### rtl/binary_fixed_point_to_ascii.sv
`timescale 1ns / 1ps
// an accepted value is registered in value_a, then in the b and c stages, then loaded into the
// serializer, which strobes its first character at once; the rest follow one per cycle, the
// sixth one carrying last; busy, paced by the single character port, stays high after each
// accept until the hold counter runs down; the next value is taken while the last still prints
// reset clears the valid bits, the busy counter and the character count
// the receiver cannot stall: every strobed character is taken in its cycle
module binary_fixed_point_to_ascii (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [bfpa_pkg::VALUE_W-1:0] value,
  output logic                           strobe,
  output logic [7:0]                     character,
  output logic                           last
);
  import bfpa_pkg::*;

  logic [CNT_W-1:0] hold;
  logic             accept;

  logic                vld_a;
  logic [VALUE_W-1:0]  value_a;
  logic                vld_b;
  logic                ovf_b;
  logic [SCALED_W-1:0] scaled_b;
  logic                vld_c;
  logic                ovf_c;
  logic [SCALED_W-1:0] scaled_c;
  logic [13:0]         q1_c;
  logic [9:0]          q2_c;
  logic [6:0]          q3_c;
  logic [3:0]          q4_c;

  logic [RAW_W+4:0]    times25;
  logic [PROD_W-1:0]   prod_10;
  logic [PROD_W-1:0]   prod_100;
  logic [PROD_W-1:0]   prod_1000;
  logic [PROD_W-1:0]   prod_10000;
  logic [3:0]          d0;
  logic [3:0]          d1;
  logic [3:0]          d2;
  logic [3:0]          d3;
  logic [3:0]          d4;
  char_t               chars [NUM_CHARS];

  assign accept = start && !busy;
  assign busy = (hold != '0);

  // holding off new items until the hold counter runs down keeps the serializer from overrunning
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= '0;
    end else if (accept) begin
      hold <= CNT_W'(NUM_CHARS - 1);
    end else if (hold != '0) begin
      hold <= hold - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
    end else begin
      vld_a <= accept;
      vld_b <= vld_a;
      vld_c <= vld_b;
    end
  end

  // x * 100 / 256 == x * 25 / 64
  assign times25 = {1'b0, value_a[RAW_W-1:0], 4'b0000}
                 + {2'b00, value_a[RAW_W-1:0], 3'b000}
                 + {5'b00000, value_a[RAW_W-1:0]};

  always_ff @(posedge clk) begin
    if (accept) begin
      value_a <= value;
    end
    ovf_b <= value_a[VALUE_W-1] || (value_a[VALUE_W-2:0] >= LIMIT_EXCL);
    scaled_b <= times25[SCALED_W+5:6];
  end

  assign prod_10    = PROD_W'(scaled_b) * PROD_W'(RECIP_10);
  assign prod_100   = PROD_W'(scaled_b) * PROD_W'(RECIP_100);
  assign prod_1000  = PROD_W'(scaled_b) * PROD_W'(RECIP_1000);
  assign prod_10000 = PROD_W'(scaled_b) * PROD_W'(RECIP_10000);

  always_ff @(posedge clk) begin
    ovf_c <= ovf_b;
    scaled_c <= scaled_b;
    q1_c <= prod_10[SHIFT_10+13:SHIFT_10];
    q2_c <= prod_100[SHIFT_100+9:SHIFT_100];
    q3_c <= prod_1000[SHIFT_1000+6:SHIFT_1000];
    q4_c <= prod_10000[SHIFT_10000+3:SHIFT_10000];
  end

  // each digit but d0 is a quotient minus ten times the next coarser one; d0 is q4_c itself
  always_comb begin
    d4 = 4'(scaled_c - SCALED_W'({q1_c, 3'b000}) - SCALED_W'({q1_c, 1'b0}));
    d3 = 4'(q1_c - 14'({q2_c, 3'b000}) - 14'({q2_c, 1'b0}));
    d2 = 4'(q2_c - 10'({q3_c, 3'b000}) - 10'({q3_c, 1'b0}));
    d1 = 4'(q3_c - 7'({q4_c, 3'b000}) - 7'({q4_c, 1'b0}));
    d0 = q4_c;
  end

  always_comb begin
    if (ovf_c) begin
      chars[0] = ASCII_STAR;
      chars[1] = ASCII_STAR;
      chars[2] = ASCII_STAR;
      chars[3] = ASCII_POINT;
      chars[4] = ASCII_STAR;
      chars[5] = ASCII_STAR;
    end else begin
      // leading zero blanking on the first two positions
      chars[0] = (d0 == 4'd0) ? ASCII_SPACE : ASCII_ZERO + char_t'(d0);
      chars[1] = (d0 == 4'd0 && d1 == 4'd0) ? ASCII_SPACE : ASCII_ZERO + char_t'(d1);
      chars[2] = ASCII_ZERO + char_t'(d2);
      chars[3] = ASCII_POINT;
      chars[4] = ASCII_ZERO + char_t'(d3);
      chars[5] = ASCII_ZERO + char_t'(d4);
    end
  end

  bfpa_serializer u_serializer (
    .clk       (clk),
    .rst       (rst),
    .load      (vld_c),
    .chars     (chars),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

endmodule

### bench/binary_fixed_point_to_ascii_tb.sv
`timescale 1ns / 1ps
module binary_fixed_point_to_ascii_tb;
  import bfpa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int NUM_ROWS = 20;
  localparam int SETTLE_CYCLES = 12;

  typedef logic [8*NUM_CHARS-1:0] field_t;

  typedef struct {
    logic signed [VALUE_W-1:0] val;
    bit                        typed;
    field_t                    text;
  } row_t;

  typedef struct {
    char_t                     ch;
    logic                      last;
    logic signed [VALUE_W-1:0] src;
    int                        pos;
  } exp_char_t;

  localparam field_t STARS = {ASCII_STAR, ASCII_STAR, ASCII_STAR,
                              ASCII_POINT, ASCII_STAR, ASCII_STAR};

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [VALUE_W-1:0] value;
  logic                      strobe;
  logic [7:0]                character;
  logic                      last;

  exp_char_t pending_chars[$];
  exp_char_t head_char;
  int        n_bad;
  int        n_items;
  int        n_starred;
  int        n_chars;
  int        cycles;

  row_t dir_rows [NUM_ROWS] = '{
    '{32'sd0,          1'b1, "  0.00"},
    '{32'sd1,          1'b0, 48'd0},
    '{32'sd3,          1'b1, "  0.01"},
    '{32'sd255,        1'b0, 48'd0},
    '{32'sd256,        1'b1, "  1.00"},
    '{32'sd2560,       1'b1, " 10.00"},
    '{32'sd25600,      1'b1, "100.00"},
    '{32'sd25613,      1'b0, 48'd0},
    '{32'sd2573,       1'b0, 48'd0},
    '{32'sd255999,     1'b1, "999.99"},
    '{32'sd256000,     1'b1, "***.**"},
    '{32'sd256001,     1'b0, 48'd0},
    '{-32'sd1,         1'b1, "***.**"},
    '{32'sh8000_0000,  1'b1, "***.**"},
    '{32'sh7FFF_FFFF,  1'b1, "***.**"},
    '{32'sh0003_FFFF,  1'b1, "***.**"},
    '{32'sd128,        1'b0, 48'd0},
    '{32'sd12800,      1'b0, 48'd0},
    '{32'sd99999,      1'b0, 48'd0},
    '{32'sd131072,     1'b0, 48'd0}
  };

  binary_fixed_point_to_ascii u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // six characters the converter should print for one value
  function automatic field_t render_fixed_point(logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] raw;
    logic [VALUE_W-1:0] scaled;
    logic [3:0]         dig [5];
    char_t              c0;
    char_t              c1;
    raw = v;
    if (raw[VALUE_W-1] || raw[VALUE_W-2:0] >= LIMIT_EXCL)
      return STARS;
    scaled = (raw * 32'd100) / 32'd256;
    for (int i = 4; i >= 0; i--) begin
      dig[i] = 4'(scaled % 10);
      scaled = scaled / 10;
    end
    c0 = (dig[0] == 0) ? ASCII_SPACE : ASCII_ZERO + char_t'(dig[0]);
    c1 = (dig[0] == 0 && dig[1] == 0) ? ASCII_SPACE : ASCII_ZERO + char_t'(dig[1]);
    return {c0, c1, ASCII_ZERO + char_t'(dig[2]), ASCII_POINT,
            ASCII_ZERO + char_t'(dig[3]), ASCII_ZERO + char_t'(dig[4])};
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return $urandom_range(255999);
    if (r < 60) return $urandom_range(2559);
    if (r < 70) return $urandom_range(256010, 255990);
    if (r < 80) return {1'b1, 31'($urandom)};
    if (r < 90) return $urandom;
    return {1'b0, 31'($urandom)};
  endfunction

  task automatic queue_field(logic signed [VALUE_W-1:0] v, field_t text);
    exp_char_t e;
    for (int k = 0; k < NUM_CHARS; k++) begin
      e.ch = text[8*(NUM_CHARS-1-k) +: 8];
      e.last = (k == NUM_CHARS - 1);
      e.src = v;
      e.pos = k;
      pending_chars.push_back(e);
    end
    if (text == STARS) n_starred++;
  endtask

  // called at a falling edge, returns at the falling edge after the accept
  task automatic send_item(logic signed [VALUE_W-1:0] v, bit typed, field_t text);
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    queue_field(v, typed ? text : render_fixed_point(v));
    n_items++;
    @(negedge clk);
  endtask

  task automatic idle_sender(int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      value <= $urandom;
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      n_chars++;
      if (pending_chars.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected character %h last=%b", character, last);
      end else begin
        head_char = pending_chars.pop_front();
        if (character !== head_char.ch || last !== head_char.last) begin
          n_bad++;
          if (n_bad <= 10)
            $display("value %0d char %0d: expected %h last=%b, got %h last=%b",
                     head_char.src, head_char.pos, head_char.ch, head_char.last,
                     character, last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d characters outstanding", pending_chars.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int pcts [3];
    pcts = '{6, 85, 0};
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    n_bad = 0;
    n_items = 0;
    n_starred = 0;
    n_chars = 0;
    cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows back to back, start held high
    foreach (dir_rows[i])
      send_item(dir_rows[i].val, dir_rows[i].typed, dir_rows[i].text);
    wait_drained();

    foreach (pcts[p]) begin
      repeat (ITEMS_PER_PHASE) begin
        send_item(pick_value(), 1'b0, 48'd0);
        idle_sender(pcts[p]);
      end
      // hold off until every character of the phase is out
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    n_bad += pending_chars.size();

    $display("converted %0d values (%0d directed, %0d out of range) into %0d characters,",
             n_items, NUM_ROWS, n_starred, n_chars);
    $display("with the sender back to back, lightly and heavily paced; %0d failures",
             n_bad);
    if (n_bad == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
